// File: rtl/harmonic_candidate_sifter_macros.svh
// ----------------------------------------------------------------------------
// Harmonic candidate sifter assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_CANDIDATE_SIFTER_MACROS_SVH
`define HARMONIC_CANDIDATE_SIFTER_MACROS_SVH

// Condition must hold at every clock edge.
`define HCS_ASSERT_ALW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define HCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// Harmonic candidate sifter package
// Field widths, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package hcs_pkg;

    localparam int SNR_W  = 24;
    localparam int PER_W  = 36;
    localparam int DM_W   = 24;
    localparam int GRP_W  = 6;
    localparam int TOL_W  = 16;
    localparam int MH_W   = 5;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 2;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_MAX_HARM = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PER_TOL  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DM_TOL   = 2'd2;

    localparam logic [MH_W-1:0]  MAX_HARM_RST = 5'd8;
    localparam logic [TOL_W-1:0] PER_TOL_RST  = 16'd1049;
    localparam logic [TOL_W-1:0] DM_TOL_RST   = 16'd6554;
    localparam int DEFAULT_HARM = 8;

    localparam int PER_SHIFT = 20;
    localparam int DM_SHIFT  = 16;

    // Data memory read address selection.
    localparam logic [1:0] RD_I   = 2'd0;
    localparam logic [1:0] RD_J   = 2'd1;
    localparam logic [1:0] RD_CUR = 2'd2;

    typedef struct packed {
        logic       load;
        logic       i_clr;
        logic       i_inc;
        logic       j_clr;
        logic       j_inc;
        logic       j_from_i;
        logic       si_lat;
        logic       rank_clr;
        logic       rank_cmp;
        logic       order_wr;
        logic [1:0] rd_sel;
        logic       ord_sel;
        logic       cur_lat;
        logic       lead_lat;
        logic       cand_lat;
        logic       test_start;
        logic       take;
        logic       push;
        logic       leader;
        logic       group_inc;
        logic       flush;
        logic       run_clr;
    } hcs_cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic taken_cur;
        logic push_ok;
        logic flush_ok;
        logic test_busy;
        logic match;
    } hcs_sts_t;

endpackage

`default_nettype wire

// File: rtl/hcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/hcs_dp.sv
// ----------------------------------------------------------------------------
// Harmonic candidate sifter datapath
// Candidate memories, rank sort, harmonic test pipeline and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "harmonic_candidate_sifter_macros.svh"

module hcs_dp #(
    parameter int MAX_CANDS      = 64,
    parameter int MAX_HARM_LIMIT = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hcs_pkg::hcs_cmd_t           cmd,
    output hcs_pkg::hcs_sts_t                sts,
    input  wire logic                        cfg_we,
    input  wire logic [hcs_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [hcs_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic [hcs_pkg::SNR_W-1:0]   in_snr,
    input  wire logic [hcs_pkg::PER_W-1:0]   in_per,
    input  wire logic [hcs_pkg::DM_W-1:0]    in_dm,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic                             m_tlast,
    output logic [hcs_pkg::GRP_W-1:0]        out_grp,
    output logic                             out_lead,
    output logic [hcs_pkg::SNR_W-1:0]        out_snr,
    output logic [hcs_pkg::PER_W-1:0]        out_per,
    output logic [hcs_pkg::DM_W-1:0]         out_dm,
    output logic                             out_ovf
);

    import hcs_pkg::*;

    localparam int IW   = $clog2(MAX_CANDS);
    localparam int CW   = $clog2(MAX_CANDS + 1);
    localparam int HW   = $clog2(MAX_HARM_LIMIT + 1);
    localparam int LW   = PER_W + HW;
    localparam int TTW  = TOL_W + HW;
    localparam int THW  = TTW + PER_W;
    localparam int CMPW = LW + PER_SHIFT;
    localparam int DPW  = DM_W + TOL_W;

    // Configuration registers.
    logic [MH_W-1:0]  mh_reg;
    logic [TOL_W-1:0] ptol_reg;
    logic [TOL_W-1:0] dtol_reg;

    // Run control.
    logic [CW-1:0]        count_reg;
    logic                 dropped_reg;
    logic [IW-1:0]        i_reg;
    logic [IW-1:0]        j_reg;
    logic [IW-1:0]        rank_reg;
    logic [IW-1:0]        cur_reg;
    logic [SNR_W-1:0]     si_reg;
    logic [GRP_W-1:0]     group_reg;

    // Memory ports.
    logic                 load_wr;
    logic [IW-1:0]        data_raddr;
    logic [IW-1:0]        ord_raddr;
    logic [SNR_W-1:0]     snr_rdata;
    logic [PER_W-1:0]     per_rdata;
    logic [DM_W-1:0]      dm_rdata;
    logic [IW-1:0]        ord_rdata;
    logic                 taken_we;
    logic [IW-1:0]        taken_waddr;
    logic [0:0]           taken_rdata;

    // Leader and candidate under test.
    logic [PER_W-1:0]     lead_per_reg;
    logic [DM_W-1:0]      lead_dm_reg;
    logic [SNR_W-1:0]     cand_snr_reg;
    logic [PER_W-1:0]     cand_per_reg;
    logic [DM_W-1:0]      cand_dm_reg;
    logic [PER_W-1:0]     big_reg;
    logic [PER_W-1:0]     small_reg;
    logic [DM_W-1:0]      dm_diff_reg;
    logic [DPW-1:0]       dm_prod_reg;

    // Harmonic pipeline.
    logic                 iss_reg;
    logic [HW-1:0]        top_reg;
    logic [HW-1:0]        bot_reg;
    logic                 v0_reg;
    logic                 v1_reg;
    logic [LW-1:0]        lhs_reg;
    logic [LW-1:0]        rhs_reg;
    logic [TTW-1:0]       tt_reg;
    logic [LW-1:0]        diff_reg;
    logic [THW-1:0]       thr_reg;
    logic                 hit_reg;
    logic [HW-1:0]        hmax;
    logic [5:0]           harm_base;
    logic [5:0]           harm_lim;

    // Result staging.
    logic                 pend_v_reg;
    logic [GRP_W-1:0]     pend_grp_reg;
    logic                 pend_lead_reg;
    logic [SNR_W-1:0]     pend_snr_reg;
    logic [PER_W-1:0]     pend_per_reg;
    logic [DM_W-1:0]      pend_dm_reg;
    logic                 pend_ovf_reg;
    logic                 out_v_reg;
    logic                 out_last_reg;
    logic [GRP_W-1:0]     out_grp_reg;
    logic                 out_lead_reg;
    logic [SNR_W-1:0]     out_snr_reg;
    logic [PER_W-1:0]     out_per_reg;
    logic [DM_W-1:0]      out_dm_reg;
    logic                 out_ovf_reg;
    logic                 out_free;
    logic                 rank_hit;

    assign load_wr = cmd.load && (count_reg < CW'(MAX_CANDS));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_I:    data_raddr = i_reg;
            RD_J:    data_raddr = j_reg;
            RD_CUR:  data_raddr = cur_reg;
            default: data_raddr = cur_reg;
        endcase
    end

    assign ord_raddr = cmd.ord_sel ? j_reg : i_reg;

    hcs_ram #(.WIDTH(SNR_W), .DEPTH(MAX_CANDS)) u_snr_ram (
        .clk   (clk),
        .we    (load_wr),
        .waddr (count_reg[IW-1:0]),
        .wdata (in_snr),
        .raddr (data_raddr),
        .rdata (snr_rdata)
    );

    hcs_ram #(.WIDTH(PER_W), .DEPTH(MAX_CANDS)) u_per_ram (
        .clk   (clk),
        .we    (load_wr),
        .waddr (count_reg[IW-1:0]),
        .wdata (in_per),
        .raddr (data_raddr),
        .rdata (per_rdata)
    );

    hcs_ram #(.WIDTH(DM_W), .DEPTH(MAX_CANDS)) u_dm_ram (
        .clk   (clk),
        .we    (load_wr),
        .waddr (count_reg[IW-1:0]),
        .wdata (in_dm),
        .raddr (data_raddr),
        .rdata (dm_rdata)
    );

    hcs_ram #(.WIDTH(IW), .DEPTH(MAX_CANDS)) u_order_ram (
        .clk   (clk),
        .we    (cmd.order_wr),
        .waddr (rank_reg),
        .wdata (i_reg),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // Each candidate's flag is cleared as it is ranked and set when it is taken.
    // The flag is read with the order entry, so it is ready when cur_reg is.
    assign taken_we    = cmd.order_wr || cmd.take;
    assign taken_waddr = cmd.order_wr ? i_reg : cur_reg;

    hcs_ram #(.WIDTH(1), .DEPTH(MAX_CANDS)) u_taken_ram (
        .clk   (clk),
        .we    (taken_we),
        .waddr (taken_waddr),
        .wdata (cmd.take),
        .raddr (ord_rdata),
        .rdata (taken_rdata)
    );

    // A zero setting means the default of eight, and the limit caps it.
    assign harm_base = (mh_reg == '0) ? 6'(DEFAULT_HARM) : {1'b0, mh_reg};
    assign harm_lim  = 6'(MAX_HARM_LIMIT);
    assign hmax      = HW'((harm_base > harm_lim) ? harm_lim : harm_base);

    // A stored candidate ranks ahead when it is stronger, or equal and earlier.
    assign rank_hit = (snr_rdata > si_reg) || ((snr_rdata == si_reg) && (j_reg < i_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mh_reg   <= MAX_HARM_RST;
            ptol_reg <= PER_TOL_RST;
            dtol_reg <= DM_TOL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_HARM: mh_reg   <= cfg_wdata[MH_W-1:0];
                CFG_PER_TOL:  ptol_reg <= cfg_wdata[TOL_W-1:0];
                CFG_DM_TOL:   dtol_reg <= cfg_wdata[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            rank_reg    <= '0;
            cur_reg     <= '0;
            group_reg   <= '0;
        end
        else
        begin
            if (cmd.run_clr)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
                group_reg   <= '0;
            end
            else
            begin
                if (load_wr)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (cmd.load)
                begin
                    dropped_reg <= 1'b1;
                end
                if (cmd.group_inc)
                begin
                    group_reg <= group_reg + GRP_W'(1);
                end
            end
            if (cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.j_clr)
            begin
                j_reg <= '0;
            end
            else if (cmd.j_from_i)
            begin
                j_reg <= i_reg + IW'(1);
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + IW'(1);
            end
            if (cmd.rank_clr)
            begin
                rank_reg <= '0;
            end
            else if (cmd.rank_cmp && rank_hit)
            begin
                rank_reg <= rank_reg + IW'(1);
            end
            if (cmd.cur_lat)
            begin
                cur_reg <= ord_rdata;
            end
        end
    end

    // Candidate and leader capture, with the per-pair operands prepared.
    always_ff @(posedge clk)
    begin
        if (cmd.si_lat)
        begin
            si_reg <= snr_rdata;
        end
        if (cmd.lead_lat)
        begin
            lead_per_reg <= per_rdata;
            lead_dm_reg  <= dm_rdata;
        end
        if (cmd.cand_lat)
        begin
            cand_snr_reg <= snr_rdata;
            cand_per_reg <= per_rdata;
            cand_dm_reg  <= dm_rdata;
            big_reg      <= (lead_per_reg >= per_rdata) ? lead_per_reg : per_rdata;
            small_reg    <= (lead_per_reg >= per_rdata) ? per_rdata : lead_per_reg;
            dm_diff_reg  <= (lead_dm_reg > dm_rdata) ? (lead_dm_reg - dm_rdata)
                                                     : (dm_rdata - lead_dm_reg);
            dm_prod_reg  <= DPW'(lead_dm_reg) * DPW'(dtol_reg);
        end
    end

    // Ratio walk: one (top, bottom) pair enters the three-stage test each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg <= 1'b0;
            top_reg <= '0;
            bot_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= iss_reg;
            v1_reg <= v0_reg;
            if (cmd.test_start)
            begin
                iss_reg <= 1'b1;
                top_reg <= HW'(1);
                bot_reg <= HW'(1);
                hit_reg <= 1'b0;
            end
            else
            begin
                if (iss_reg)
                begin
                    if (bot_reg == top_reg)
                    begin
                        if (top_reg == hmax)
                        begin
                            iss_reg <= 1'b0;
                        end
                        else
                        begin
                            top_reg <= top_reg + HW'(1);
                            bot_reg <= HW'(1);
                        end
                    end
                    else
                    begin
                        bot_reg <= bot_reg + HW'(1);
                    end
                end
                if (v1_reg && ({diff_reg, PER_SHIFT'(0)} < CMPW'(thr_reg)))
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lhs_reg  <= LW'(big_reg) * LW'(bot_reg);
        rhs_reg  <= LW'(small_reg) * LW'(top_reg);
        tt_reg   <= TTW'(ptol_reg) * TTW'(top_reg);
        diff_reg <= (lhs_reg > rhs_reg) ? (lhs_reg - rhs_reg) : (rhs_reg - lhs_reg);
        thr_reg  <= THW'(tt_reg) * THW'(small_reg);
    end

    // One result waits in the staging register so the final one can carry tlast.
    assign out_free = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
            end
            else if (cmd.push)
            begin
                pend_v_reg <= 1'b1;
            end
            if (cmd.flush || (cmd.push && pend_v_reg))
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush || (cmd.push && pend_v_reg))
        begin
            out_grp_reg  <= pend_grp_reg;
            out_lead_reg <= pend_lead_reg;
            out_snr_reg  <= pend_snr_reg;
            out_per_reg  <= pend_per_reg;
            out_dm_reg   <= pend_dm_reg;
            out_ovf_reg  <= pend_ovf_reg;
            out_last_reg <= cmd.flush;
        end
        if (cmd.push)
        begin
            pend_grp_reg  <= group_reg;
            pend_lead_reg <= cmd.leader;
            pend_snr_reg  <= cand_snr_reg;
            pend_per_reg  <= cand_per_reg;
            pend_dm_reg   <= cand_dm_reg;
            pend_ovf_reg  <= dropped_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign out_grp  = out_grp_reg;
    assign out_lead = out_lead_reg;
    assign out_snr  = out_snr_reg;
    assign out_per  = out_per_reg;
    assign out_dm   = out_dm_reg;
    assign out_ovf  = out_ovf_reg;

    assign sts.i_last    = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign sts.j_last    = ((CW'(j_reg) + CW'(1)) == count_reg);
    assign sts.taken_cur = taken_rdata[0];
    assign sts.push_ok   = !pend_v_reg || out_free;
    assign sts.flush_ok  = out_free;
    assign sts.test_busy = iss_reg || v0_reg || v1_reg;
    assign sts.match     = hit_reg && ({dm_diff_reg, DM_SHIFT'(0)} < dm_prod_reg);

    `HCS_ASSERT_ALW(a_count_bound, count_reg <= CW'(MAX_CANDS), "load count past capacity")
    `HCS_ASSERT_NXT(a_flush_moves, cmd.flush, out_v_reg && !pend_v_reg, "flush lost result")
    `HCS_ASSERT_IMP(a_hit_from_pipe, $rose(hit_reg), $past(v1_reg), "match without test")

endmodule

`default_nettype wire

// File: rtl/hcs_ctrl.sv
// ----------------------------------------------------------------------------
// Harmonic candidate sifter controller
// Sequences loading, rank sort, group walk, harmonic tests and result pushes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "harmonic_candidate_sifter_macros.svh"

module hcs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    input  wire hcs_pkg::hcs_sts_t sts,
    output hcs_pkg::hcs_cmd_t      cmd
);

    import hcs_pkg::*;

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_R_A    = 5'd1;
    localparam logic [4:0] ST_R_B    = 5'd2;
    localparam logic [4:0] ST_R_C    = 5'd3;
    localparam logic [4:0] ST_R_D    = 5'd4;
    localparam logic [4:0] ST_R_W    = 5'd5;
    localparam logic [4:0] ST_P_RD   = 5'd6;
    localparam logic [4:0] ST_P_CUR  = 5'd7;
    localparam logic [4:0] ST_P_CHK  = 5'd8;
    localparam logic [4:0] ST_P_DAT  = 5'd9;
    localparam logic [4:0] ST_P_PUSH = 5'd10;
    localparam logic [4:0] ST_Q_RD   = 5'd11;
    localparam logic [4:0] ST_Q_CUR  = 5'd12;
    localparam logic [4:0] ST_Q_CHK  = 5'd13;
    localparam logic [4:0] ST_Q_DAT  = 5'd14;
    localparam logic [4:0] ST_Q_TEST = 5'd15;
    localparam logic [4:0] ST_Q_END  = 5'd16;
    localparam logic [4:0] ST_G_END  = 5'd17;
    localparam logic [4:0] ST_FLUSH  = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.i_clr  = 1'b1;
                        state_next = ST_R_A;
                    end
                end
            end
            ST_R_A:
            begin
                cmd.rd_sel = RD_I;
                state_next = ST_R_B;
            end
            ST_R_B:
            begin
                cmd.si_lat   = 1'b1;
                cmd.j_clr    = 1'b1;
                cmd.rank_clr = 1'b1;
                state_next   = ST_R_C;
            end
            ST_R_C:
            begin
                cmd.rd_sel = RD_J;
                state_next = ST_R_D;
            end
            ST_R_D:
            begin
                cmd.rd_sel   = RD_J;
                cmd.rank_cmp = 1'b1;
                if (sts.j_last)
                begin
                    state_next = ST_R_W;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_R_C;
                end
            end
            ST_R_W:
            begin
                cmd.order_wr = 1'b1;
                if (sts.i_last)
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = ST_P_RD;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_R_A;
                end
            end
            ST_P_RD:
            begin
                state_next = ST_P_CUR;
            end
            ST_P_CUR:
            begin
                cmd.cur_lat = 1'b1;
                state_next  = ST_P_CHK;
            end
            ST_P_CHK:
            begin
                if (sts.taken_cur)
                begin
                    if (sts.i_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_P_RD;
                    end
                end
                else
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_P_DAT;
                end
            end
            ST_P_DAT:
            begin
                cmd.lead_lat = 1'b1;
                cmd.cand_lat = 1'b1;
                state_next   = ST_P_PUSH;
            end
            ST_P_PUSH:
            begin
                if (sts.push_ok)
                begin
                    cmd.push   = 1'b1;
                    cmd.leader = 1'b1;
                    if (sts.i_last)
                    begin
                        state_next = ST_G_END;
                    end
                    else
                    begin
                        cmd.j_from_i = 1'b1;
                        state_next   = ST_Q_RD;
                    end
                end
            end
            ST_Q_RD:
            begin
                cmd.ord_sel = 1'b1;
                state_next  = ST_Q_CUR;
            end
            ST_Q_CUR:
            begin
                cmd.cur_lat = 1'b1;
                state_next  = ST_Q_CHK;
            end
            ST_Q_CHK:
            begin
                if (sts.taken_cur)
                begin
                    if (sts.j_last)
                    begin
                        state_next = ST_G_END;
                    end
                    else
                    begin
                        cmd.j_inc  = 1'b1;
                        state_next = ST_Q_RD;
                    end
                end
                else
                begin
                    state_next = ST_Q_DAT;
                end
            end
            ST_Q_DAT:
            begin
                cmd.cand_lat   = 1'b1;
                cmd.test_start = 1'b1;
                state_next     = ST_Q_TEST;
            end
            ST_Q_TEST:
            begin
                if (!sts.test_busy)
                begin
                    state_next = ST_Q_END;
                end
            end
            ST_Q_END:
            begin
                // A matching member waits here until the staging register has room.
                if (!sts.match || sts.push_ok)
                begin
                    cmd.push = sts.match;
                    cmd.take = sts.match;
                    if (sts.j_last)
                    begin
                        state_next = ST_G_END;
                    end
                    else
                    begin
                        cmd.j_inc  = 1'b1;
                        state_next = ST_Q_RD;
                    end
                end
            end
            ST_G_END:
            begin
                cmd.group_inc = 1'b1;
                if (sts.i_last)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_P_RD;
                end
            end
            ST_FLUSH:
            begin
                if (sts.flush_ok)
                begin
                    cmd.flush   = 1'b1;
                    cmd.run_clr = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `HCS_ASSERT_IMP(a_push_room, cmd.push, sts.push_ok, "push without room")
    `HCS_ASSERT_NXT(a_test_runs, cmd.test_start, sts.test_busy, "test did not start")

endmodule

`default_nettype wire

// File: rtl/harmonic_candidate_sifter.sv
// Load: accepts a candidate on each valid beat while loading; a run of n candidates sifts after last.
// Sort: one memory read per rank compare.
// Each pairwise test walks H*(H+1)/2 ratio pairs through one pipelined
// multiply-compare unit (H = effective max harmonic).
// A result leaves once the next one is found; the last leaves with tlast.
// Reset (rst_n low, asynchronous) restores register defaults and empties the run.
// ----------------------------------------------------------------------------
// Harmonic candidate sifter top level
// Groups harmonically related candidates by descending signal-to-noise.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_candidate_sifter #(
    parameter int MAX_CANDS      = 64,
    parameter int MAX_HARM_LIMIT = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // snr[23:0], period_ns[59:24], dm_milli[83:60], zero fill
    input  wire logic [hcs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // group_index[5:0], snr_out[29:6], period_out[65:30], dm_out[89:66], zero fill
    output logic      [hcs_pkg::M_TDATA_W-1:0]   m_tdata,
    // is_leader[0], overflow[1]
    output logic      [hcs_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [hcs_pkg::CFG_AW-1:0]      cfg_addr,
    input  wire logic [hcs_pkg::CFG_DW-1:0]      cfg_wdata
);

    import hcs_pkg::*;

    localparam int OUT_BITS = GRP_W + SNR_W + PER_W + DM_W;

    hcs_cmd_t         cmd;
    hcs_sts_t         sts;
    logic [GRP_W-1:0] out_grp;
    logic             out_lead;
    logic [SNR_W-1:0] out_snr;
    logic [PER_W-1:0] out_per;
    logic [DM_W-1:0]  out_dm;
    logic             out_ovf;

    hcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hcs_dp #(
        .MAX_CANDS      (MAX_CANDS),
        .MAX_HARM_LIMIT (MAX_HARM_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_snr    (s_tdata[SNR_W-1:0]),
        .in_per    (s_tdata[SNR_W+PER_W-1:SNR_W]),
        .in_dm     (s_tdata[SNR_W+PER_W+DM_W-1:SNR_W+PER_W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .out_grp   (out_grp),
        .out_lead  (out_lead),
        .out_snr   (out_snr),
        .out_per   (out_per),
        .out_dm    (out_dm),
        .out_ovf   (out_ovf)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}}, out_dm, out_per, out_snr, out_grp};
    assign m_tuser = {out_ovf, out_lead};

endmodule

`default_nettype wire

// File: test/harmonic_candidate_sifter_tb.sv
// ----------------------------------------------------------------------------
// Harmonic candidate sifter testbench
// Streams candidate lists into the sifter under random source gaps and sink
// stalls, changes the match registers between lists, and checks every emitted
// candidate against a behavioral grouping predictor kept in this file.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_candidate_sifter_tb;

    import hcs_pkg::*;

    localparam int NCAND     = 64;
    localparam int HARM_CAP  = 16;
    localparam int STALL_PCT = 19;
    localparam int WD_LIMIT  = 1000000;
    localparam int RAND_ITEMS = 400;

    typedef struct {
        logic [SNR_W-1:0] snr;
        logic [PER_W-1:0] per;
        logic [DM_W-1:0]  dm;
    } cand_t;

    typedef struct packed {
        logic [GRP_W-1:0] grp;
        logic             lead;
        logic [SNR_W-1:0] snr;
        logic [PER_W-1:0] per;
        logic [DM_W-1:0]  dm;
        logic             ovf;
        logic             lst;
    } sifted_t;

    typedef struct {
        logic [SNR_W-1:0] snr;
        logic [PER_W-1:0] per;
        logic [DM_W-1:0]  dm;
        logic             lst;
        bit               typed;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    // Copy of the registers and the list being collected.
    logic [MH_W-1:0]  harm_reg;
    logic [TOL_W-1:0] ptol_reg;
    logic [TOL_W-1:0] dmtol_reg;
    cand_t pending[$];
    bit    lost_any;

    sifted_t sifted_q[$];
    int      errors;
    int      quiet_cycles;
    bit      calm;

    harmonic_candidate_sifter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit period_match(logic [63:0] pa, logic [63:0] pb);
        logic [63:0] big;
        logic [63:0] lesser;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [63:0] diff;
        int hmax;
        hmax = (harm_reg == 0) ? DEFAULT_HARM : int'(harm_reg);
        if (hmax > HARM_CAP)
            hmax = HARM_CAP;
        big = (pa >= pb) ? pa : pb;
        lesser = (pa >= pb) ? pb : pa;
        for (int top = 1; top <= hmax; top++)
        begin
            for (int bot = 1; bot <= top; bot++)
            begin
                lhs = big * 64'(bot);
                rhs = lesser * 64'(top);
                diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
                if ((diff << PER_SHIFT) < 64'(ptol_reg) * 64'(top) * lesser)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit dm_match(logic [63:0] dl, logic [63:0] dc);
        logic [63:0] diff;
        diff = (dl > dc) ? dl - dc : dc - dl;
        return (diff << DM_SHIFT) < dl * 64'(dmtol_reg);
    endfunction

    // Orders the collected list by falling SNR (stable) and forms the groups.
    task automatic group_candidates();
        int n;
        int j;
        int lead;
        int m;
        int grp;
        int order[NCAND];
        bit taken[NCAND];
        sifted_t burst[$];
        n = pending.size();
        for (int i = 0; i < n; i++)
        begin
            j = i;
            while (j > 0 && pending[order[j-1]].snr < pending[i].snr)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            taken[i] = 1'b0;
        end
        grp = 0;
        for (int p = 0; p < n; p++)
        begin
            lead = order[p];
            if (!taken[lead])
            begin
                taken[lead] = 1'b1;
                burst.insert(burst.size(), '{GRP_W'(grp), 1'b1, pending[lead].snr,
                                             pending[lead].per, pending[lead].dm,
                                             lost_any, 1'b0});
                for (int q = p + 1; q < n; q++)
                begin
                    m = order[q];
                    if (!taken[m] && period_match(pending[lead].per, pending[m].per)
                        && dm_match(pending[lead].dm, pending[m].dm))
                    begin
                        taken[m] = 1'b1;
                        burst.insert(burst.size(), '{GRP_W'(grp), 1'b0, pending[m].snr,
                                                     pending[m].per, pending[m].dm,
                                                     lost_any, 1'b0});
                    end
                end
                grp++;
            end
        end
        burst[burst.size()-1].lst = 1'b1;
        foreach (burst[k])
            sifted_q.insert(sifted_q.size(), burst[k]);
    endtask

    task automatic note_request(cand_t c, logic lst, bit typed);
        if (pending.size() < NCAND)
            pending.insert(pending.size(), c);
        else
            lost_any = 1'b1;
        if (lst)
        begin
            if (typed)
                sifted_q.insert(sifted_q.size(), '{'0, 1'b1, c.snr, c.per, c.dm, 1'b0, 1'b1});
            else
                group_candidates();
            pending.delete();
            lost_any = 1'b0;
        end
    endtask

    task automatic send(cand_t c, logic lst, bit typed);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, c.dm, c.per, c.snr};
        s_tlast <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        note_request(c, lst, typed);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        while (sifted_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_HARM: harm_reg = val[MH_W-1:0];
            CFG_PER_TOL:  ptol_reg = val;
            default:      dmtol_reg = val;
        endcase
    endtask

    // A list of related candidates: mostly harmonics of one base period with a
    // DM close to a base DM, mixed with unrelated and full-range candidates.
    task automatic random_list(int n);
        cand_t c;
        logic [63:0] base_p;
        logic [63:0] p;
        logic [DM_W-1:0] base_dm;
        logic [SNR_W-1:0] tie_snr;
        int top;
        int bot;
        base_p = 64'($urandom_range(32'h7FFF_FFFF, 64));
        base_dm = $urandom;
        tie_snr = $urandom;
        for (int i = 0; i < n; i++)
        begin
            top = $urandom_range(HARM_CAP, 1);
            bot = $urandom_range(top, 1);
            case ($urandom_range(9))
                0, 1: p = {$urandom, $urandom};
                2:    p = base_p;
                default:
                    p = ($urandom_range(1)) ? base_p * top / bot : base_p * bot / top;
            endcase
            if ($urandom_range(3) == 0)
                p = p + $urandom_range(3);
            c.per = p[PER_W-1:0];
            c.snr = ($urandom_range(3) == 0) ? tie_snr : SNR_W'($urandom);
            case ($urandom_range(5))
                0:       c.dm = $urandom;
                1:       c.dm = base_dm;
                default: c.dm = base_dm + DM_W'($urandom_range(64)) - 24'd32;
            endcase
            send(c, i == n - 1, 1'b0);
        end
    endtask

    task automatic random_phase(int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            random_list(n);
            sent += n;
        end
    endtask

    // Sink side: random stalls and the comparison against the oldest expectation.
    always @(posedge clk)
    begin
        sifted_t got;
        sifted_t want;
        if (rst_n)
            m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[5:0], m_tuser[0], m_tdata[29:6], m_tdata[65:30],
                    m_tdata[89:66], m_tuser[1], m_tlast};
            if (sifted_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
            end
            else
            begin
                want = sifted_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    row_t rows[] = '{
        '{24'hFFFFFF, 36'hF_FFFF_FFFF, 24'hFFFFFF, 1'b1, 1'b1},
        '{24'h000000, 36'd1,           24'h000000, 1'b1, 1'b1},
        '{24'hAAAAAA, 36'h5_5555_5555, 24'h555555, 1'b1, 1'b1},
        '{24'h555555, 36'hA_AAAA_AAAA, 24'hAAAAAA, 1'b1, 1'b1},
        '{24'h000100, 36'd0,           24'd1000,   1'b1, 1'b1},
        // Zero periods never match, even with equal DM.
        '{24'd500,    36'd0,           24'd1000,   1'b0, 1'b0},
        '{24'd400,    36'd0,           24'd1000,   1'b1, 1'b0},
        // Harmonic family with SNR ties, one DM outlier and one stranger.
        '{24'h001000, 36'd1000000,     24'd50000,  1'b0, 1'b0},
        '{24'h000800, 36'd2000000,     24'd50000,  1'b0, 1'b0},
        '{24'h000800, 36'd3000001,     24'd50000,  1'b0, 1'b0},
        '{24'h000900, 36'd1500000,     24'd50000,  1'b0, 1'b0},
        '{24'h000400, 36'd1000000,     24'd90000,  1'b0, 1'b0},
        '{24'h000800, 36'd7777777,     24'd50000,  1'b1, 1'b0},
        // Ninth harmonic lies beyond the default ratio range.
        '{24'h002000, 36'd1000000,     24'd10000,  1'b0, 1'b0},
        '{24'h000100, 36'd9000000,     24'd10000,  1'b1, 1'b0},
        // A leader with zero DM accepts nobody.
        '{24'd300,    36'd5000,        24'd0,      1'b0, 1'b0},
        '{24'd200,    36'd5000,        24'd0,      1'b1, 1'b0}
    };

    initial
    begin
        cand_t c;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        errors = 0;
        calm = 1'b0;
        lost_any = 1'b0;
        harm_reg = MAX_HARM_RST;
        ptol_reg = PER_TOL_RST;
        dmtol_reg = DM_TOL_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            c = '{rows[r].snr, rows[r].per, rows[r].dm};
            send(c, rows[r].lst, rows[r].typed);
        end

        random_phase(RAND_ITEMS / 6);
        s_tvalid <= 1'b0;

        // Single ratio and zero tolerances: every candidate stands alone.
        // A list past capacity, ending on a dropped request, runs here too.
        write_reg(CFG_MAX_HARM, 16'd1);
        write_reg(CFG_PER_TOL, 16'd0);
        write_reg(CFG_DM_TOL, 16'd0);
        random_list(NCAND + 2);
        random_phase(RAND_ITEMS / 12);
        s_tvalid <= 1'b0;

        write_reg(CFG_MAX_HARM, 16'd16);
        write_reg(CFG_PER_TOL, 16'hFFFF);
        write_reg(CFG_DM_TOL, 16'hFFFF);
        random_phase(RAND_ITEMS / 6);
        s_tvalid <= 1'b0;

        // Out-of-range harmonic limit saturates; no stalls on either side here.
        write_reg(CFG_MAX_HARM, 16'd31);
        write_reg(CFG_PER_TOL, 16'd2000);
        write_reg(CFG_DM_TOL, 16'd30000);
        calm = 1'b1;
        random_phase(RAND_ITEMS / 6);
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Zero harmonic limit falls back to the default.
        write_reg(CFG_MAX_HARM, 16'd0);
        write_reg(CFG_PER_TOL, 16'd1049);
        write_reg(CFG_DM_TOL, 16'd6554);
        random_phase(RAND_ITEMS / 6);
        s_tvalid <= 1'b0;

        write_reg(CFG_MAX_HARM, 16'd3);
        write_reg(CFG_PER_TOL, 16'd20000);
        write_reg(CFG_DM_TOL, 16'd65535);
        random_phase(RAND_ITEMS / 6);
        s_tvalid <= 1'b0;

        while (sifted_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
